// File: rtl/core/cumulative_ack_receive_window_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the receive window checkers.
// ----------------------------------------------------------------------------
`ifndef CUMULATIVE_ACK_RECEIVE_WINDOW_MACROS_SVH
`define CUMULATIVE_ACK_RECEIVE_WINDOW_MACROS_SVH

// same-cycle implication
`define CAWR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("receive window assertion failed");

// next-cycle implication
`define CAWR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("receive window assertion failed");

`endif

// File: rtl/core/cawr_pkg.sv
// ----------------------------------------------------------------------------
// cawr_pkg
// Types and constants of the cumulative ack receive window.
// ----------------------------------------------------------------------------
package cawr_pkg;

    localparam int WINDOW_DEF = 256;
    localparam int SEQ_W      = 31;
    localparam int ACK_W      = 32;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic below;
        logic beyond;
        logic hit;
    } t_class;

endpackage

// File: rtl/core/cawr_in_if.sv
// ----------------------------------------------------------------------------
// cawr_in_if
// Segment channel: one word is a data segment or a finish marker.
// ----------------------------------------------------------------------------
interface cawr_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [cawr_pkg::SEQ_W-1:0] seq_num;

    modport source (output valid, output kind, output seq_num, input ready);
    modport sink   (input valid, input kind, input seq_num, output ready);
endinterface

// File: rtl/core/cawr_out_if.sv
// ----------------------------------------------------------------------------
// cawr_out_if
// Ack channel: one word per accepted segment word.
// ----------------------------------------------------------------------------
interface cawr_out_if;
    logic                              valid;
    logic                              ready;
    logic                              ack_sent;
    logic signed [cawr_pkg::ACK_W-1:0] ack_num;
    logic                              done_res;
    logic                              dropped;

    modport source (output valid, output ack_sent, output ack_num, output done_res,
                    output dropped, input ready);
    modport sink   (input valid, input ack_sent, input ack_num, input done_res,
                    input dropped, output ready);
endinterface

// File: rtl/core/cawr_bitmap.sv
// ----------------------------------------------------------------------------
// cawr_bitmap
// Received-slot bitmap: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cawr_bitmap #(
    parameter int DEPTH = cawr_pkg::WINDOW_DEF,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cawr_classify.sv
// ----------------------------------------------------------------------------
// cawr_classify
// Places a segment number against the window and finds its bitmap slot.
// ----------------------------------------------------------------------------
module cawr_classify #(
    parameter int WINDOW = cawr_pkg::WINDOW_DEF,
    parameter int SW     = 8
) (
    input  logic [cawr_pkg::SEQ_W-1:0] i_seq,
    input  logic [cawr_pkg::ACK_W-1:0] i_exp,
    input  logic [SW-1:0]              i_exp_slot,
    output cawr_pkg::t_class           o_class,
    output logic [SW-1:0]              o_slot
);

    logic [cawr_pkg::ACK_W-1:0] seq_ext;
    logic [cawr_pkg::ACK_W-1:0] diff;
    logic [SW:0]                sum;

    always_comb begin
        seq_ext        = {1'b0, i_seq};
        diff           = seq_ext - i_exp;
        o_class.below  = seq_ext < i_exp;
        o_class.hit    = seq_ext == i_exp;
        o_class.beyond = !o_class.below && (diff >= cawr_pkg::ACK_W'(WINDOW));
        // offset is below WINDOW when in window: one conditional subtract
        sum = {1'b0, i_exp_slot} + {1'b0, diff[SW-1:0]};
        if (sum >= (SW+1)'(WINDOW)) begin
            o_slot = SW'(sum - (SW+1)'(WINDOW));
        end else begin
            o_slot = sum[SW-1:0];
        end
    end

endmodule

// File: rtl/core/cumulative_ack_receive_window.sv
// ----------------------------------------------------------------------------
// cumulative_ack_receive_window
// Receiver window with cumulative acks.
//
// i_in carries segment words (kind, seq_num); o_out returns one ack word per
// segment word: ack_sent, ack_num (expected - 1), done_res and dropped.
// A word that does not advance the expected number is registered in ST_EMIT
// and then in the output register. A segment equal to the expected number walks
// the bitmap memory, one slot per cycle, past the already received slots that
// follow it. The walk through the single read port of the bitmap sets the
// rate; no new segment word is taken until the ack of the last one is loaded
// into the output register.
// After reset the bitmap is cleared one slot per cycle, with i_in.ready low.
// The next segment word is taken while the previous ack still waits in the
// output register; a stalled o_out holds that word and the block stops before
// loading the following one.
// ----------------------------------------------------------------------------
module cumulative_ack_receive_window #(
    parameter int WINDOW = cawr_pkg::WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cawr_in_if.sink           i_in,
    cawr_out_if.source        o_out
);

    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    cawr_pkg::t_state           r_state, n_state;
    logic [cawr_pkg::ACK_W-1:0] r_exp, n_exp;
    logic [SW-1:0]              r_exp_slot, n_exp_slot;
    logic [cawr_pkg::SEQ_W-1:0] r_high, n_high;
    logic                       r_fin, n_fin;
    logic                       r_done, n_done;
    logic [SW-1:0]              r_clr, n_clr;
    logic                       r_sent, n_sent;
    logic                       r_drop, n_drop;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_sent, n_out_sent;
    logic [cawr_pkg::ACK_W-1:0] r_out_ack, n_out_ack;
    logic                       r_out_done, n_out_done;
    logic                       r_out_drop, n_out_drop;

    cawr_pkg::t_class           cls;
    logic [SW-1:0]              cls_slot;
    logic [SW-1:0]              slot_inc;
    logic                       exp_gt;
    logic                       in_ready;
    logic                       mem_we;
    logic [SW-1:0]              mem_waddr;
    logic                       mem_wdata;
    logic                       mem_re;
    logic                       mem_rdata;

    cawr_classify #(
        .WINDOW (WINDOW),
        .SW     (SW)
    ) u_classify (
        .i_seq      (i_in.seq_num),
        .i_exp      (r_exp),
        .i_exp_slot (r_exp_slot),
        .o_class    (cls),
        .o_slot     (cls_slot)
    );

    cawr_bitmap #(
        .DEPTH (WINDOW),
        .AW    (SW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (n_exp_slot),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cawr_pkg::ST_CLEAR;
            r_exp       <= '0;
            r_exp_slot  <= '0;
            r_high      <= '0;
            r_fin       <= 1'b0;
            r_done      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_exp_slot  <= n_exp_slot;
            r_high      <= n_high;
            r_fin       <= n_fin;
            r_done      <= n_done;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sent     <= n_sent;
        r_drop     <= n_drop;
        r_out_sent <= n_out_sent;
        r_out_ack  <= n_out_ack;
        r_out_done <= n_out_done;
        r_out_drop <= n_out_drop;
    end

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_exp_slot  = r_exp_slot;
        n_high      = r_high;
        n_fin       = r_fin;
        n_done      = r_done;
        n_clr       = r_clr;
        n_sent      = r_sent;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_out_sent  = r_out_sent;
        n_out_ack   = r_out_ack;
        n_out_done  = r_out_done;
        n_out_drop  = r_out_drop;
        mem_we      = 1'b0;
        mem_waddr   = cls_slot;
        mem_wdata   = 1'b0;
        mem_re      = 1'b0;
        in_ready    = 1'b0;
        slot_inc    = (r_exp_slot == SW'(WINDOW - 1)) ? '0 : r_exp_slot + 1'b1;
        exp_gt      = r_exp > {1'b0, r_high};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            cawr_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SW'(WINDOW - 1)) begin
                    n_state = cawr_pkg::ST_IDLE;
                end
            end
            cawr_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = cawr_pkg::ST_EMIT;
                    n_sent  = 1'b1;
                    n_drop  = 1'b0;
                    if (r_done) begin
                        n_sent = 1'b0;
                    end else if (i_in.kind == cawr_pkg::KIND_FINISH) begin
                        n_fin  = 1'b1;
                        n_sent = !exp_gt;
                    end else if (cls.below) begin
                        n_sent = 1'b1;
                    end else if (cls.beyond) begin
                        n_drop = 1'b1;
                    end else begin
                        if (i_in.seq_num > r_high) begin
                            n_high = i_in.seq_num;
                        end
                        if (cls.hit) begin
                            // slot of expected is never set: step past it directly
                            n_exp      = r_exp + 1'b1;
                            n_exp_slot = slot_inc;
                            mem_re     = 1'b1;
                            n_state    = cawr_pkg::ST_WALK;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = 1'b1;
                        end
                    end
                end
            end
            cawr_pkg::ST_WALK: begin
                if (mem_rdata && !r_exp[cawr_pkg::ACK_W-1]) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_exp_slot;
                    n_exp      = r_exp + 1'b1;
                    n_exp_slot = slot_inc;
                    mem_re     = 1'b1;
                end else begin
                    n_state = cawr_pkg::ST_EMIT;
                end
            end
            cawr_pkg::ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_done      = r_done || (r_fin && exp_gt);
                    n_out_valid = 1'b1;
                    n_out_sent  = r_sent;
                    n_out_ack   = r_exp - 1'b1;
                    n_out_done  = n_done;
                    n_out_drop  = r_drop;
                    n_state     = cawr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cawr_pkg::ST_CLEAR;
            end
        endcase
    end

    assign i_in.ready     = in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.ack_sent = r_out_sent;
    assign o_out.ack_num  = signed'(r_out_ack);
    assign o_out.done_res = r_out_done;
    assign o_out.dropped  = r_out_drop;

endmodule

// File: rtl/core/cawr_checker.sv
// ----------------------------------------------------------------------------
// cawr_checker
// Port-level checks of the receive window, bound to the top level.
// ----------------------------------------------------------------------------
`include "cumulative_ack_receive_window_macros.svh"

module cawr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_sent,
    input logic i_out_done,
    input logic i_out_drop
);

    `CAWR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `CAWR_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, i_out_valid && i_out_done, !i_out_valid || i_out_done)
    `CAWR_ASSERT_IMPLY(a_drop_acked, i_clk, i_rst_n, i_out_valid && i_out_drop, i_out_sent && !i_out_done)
    `CAWR_ASSERT_IMPLY(a_silent_done, i_clk, i_rst_n, i_out_valid && !i_out_sent, i_out_done)

endmodule

bind cumulative_ack_receive_window cawr_checker u_cawr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_sent  (o_out.ack_sent),
    .i_out_done  (o_out.done_res),
    .i_out_drop  (o_out.dropped)
);
